@@ rtl/core/uep0_pkg.sv @@
// ----------------------------------------------------------------------------
// uep0_pkg - endpoint-zero control sequencer package
// Codes, payload structs and state struct shared by the sequencer files.
// ----------------------------------------------------------------------------
package uep0_pkg;

  localparam int LEN_W      = 16;
  localparam int PKT_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [PKT_W-1:0] MAX_PACKET_RST  = PKT_W'(64);
  localparam logic [LEN_W-1:0] RX_CAPACITY_RST = LEN_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_PACKET  = 1'b0,
    CFG_RX_CAPACITY = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_SETUP  = 2'd0,
    EV_OUT    = 2'd1,
    EV_IN     = 2'd2,
    EV_UNUSED = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    RESP_ACK  = 2'd0,
    RESP_NAK  = 2'd1,
    RESP_FAIL = 2'd2,
    RESP_BAD  = 2'd3
  } resp_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_ZLP   = 2'd2,
    ACT_STALL = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_RXDATA     = 3'd1,
    PH_TXDATA     = 3'd2,
    PH_TXZLP      = 3'd3,
    PH_TXCOMP     = 3'd4,
    PH_STATUS_OUT = 3'd5,
    PH_STATUS_IN  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [1:0]       func;
    logic             setup_to_host;
    logic [LEN_W-1:0] setup_length;
    logic [PKT_W-1:0] out_len;
    logic [1:0]       handler_resp;
    logic [LEN_W-1:0] reply_len;
  } item_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [PKT_W-1:0] in_len;
    logic [LEN_W-1:0] in_offset;
    logic             request_taken;
    logic             complete;
    logic [2:0]       phase;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_write_t;

  typedef struct packed {
    logic [PKT_W-1:0] max_packet;
    logic [LEN_W-1:0] rx_capacity;
  } cfg_regs_t;

  typedef struct packed {
    phase_t           phase;
    logic [LEN_W-1:0] rx_left;
    logic [LEN_W-1:0] tx_left;
    logic [LEN_W-1:0] tx_sent;
    logic             latched_to_host;
    logic [LEN_W-1:0] latched_length;
  } seq_state_t;

endpackage

@@ rtl/core/uep0_stream_if.sv @@
// ----------------------------------------------------------------------------
// uep0_stream_if - valid/ready channel
// One transfer per clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface uep0_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/uep0_step.sv @@
// ----------------------------------------------------------------------------
// uep0_step - one control-transfer event
// Combinational next state and result for a single endpoint event.
// ----------------------------------------------------------------------------
module uep0_step
  import uep0_pkg::*;
(
  input  item_t      item,
  input  seq_state_t st,
  input  cfg_regs_t  regs,
  output seq_state_t st_next,
  output result_t    res
);

  logic             lth;
  logic [LEN_W-1:0] llen;
  phase_t           ph_in;
  logic             do_out;
  logic             do_in;
  logic [LEN_W-1:0] rx_rem;
  logic [LEN_W-1:0] reply_clip;
  logic [LEN_W-1:0] mp_ext;
  // shared send unit
  logic             snd_first;
  logic [LEN_W-1:0] snd_left;
  logic [LEN_W-1:0] snd_base;
  logic [LEN_W-1:0] snd_n;
  logic [LEN_W-1:0] snd_left_next;
  logic             want_process;
  logic             want_send;

  always_comb begin
    lth    = (item.func == EV_SETUP) ? item.setup_to_host : st.latched_to_host;
    llen   = (item.func == EV_SETUP) ? item.setup_length  : st.latched_length;
    ph_in  = (item.func == EV_SETUP) ? PH_IDLE : st.phase;
    do_out = (item.func == EV_SETUP) || (item.func == EV_OUT);
    do_in  = (item.func == EV_IN);
    rx_rem = st.rx_left - LEN_W'(item.out_len);
    reply_clip = (item.reply_len >= llen) ? llen : item.reply_len;
    mp_ext = LEN_W'(regs.max_packet);
  end

  // request processing happens from idle (no data stage) or at end of rx data
  always_comb begin
    want_process = 1'b0;
    if (do_out) begin
      if (ph_in == PH_IDLE) begin
        want_process = !(!lth && llen != '0);
      end else if (ph_in == PH_RXDATA) begin
        want_process = (st.rx_left >= LEN_W'(item.out_len)) && (rx_rem == '0);
      end
    end
  end

  always_comb begin
    snd_first     = want_process;
    snd_left      = snd_first ? reply_clip : st.tx_left;
    snd_base      = snd_first ? '0 : st.tx_sent;
    snd_n         = (snd_left < mp_ext) ? snd_left : mp_ext;
    snd_left_next = snd_left - snd_n;
    want_send     = (want_process && item.handler_resp == RESP_ACK && lth) ||
                    (do_in && st.phase == PH_TXDATA);
  end

  always_comb begin
    st_next        = st;
    st_next.phase  = ph_in;
    res            = '0;

    if (item.func == EV_SETUP) begin
      st_next.latched_to_host = item.setup_to_host;
      st_next.latched_length  = item.setup_length;
    end

    if (do_out) begin
      unique case (ph_in)
        PH_IDLE: begin
          if (!lth && llen != '0) begin
            if (llen > regs.rx_capacity) begin
              res.action    = ACT_STALL;
              st_next.phase = PH_IDLE;
            end else begin
              st_next.phase   = PH_RXDATA;
              st_next.rx_left = llen;
            end
          end
        end
        PH_RXDATA: begin
          if (st.rx_left < LEN_W'(item.out_len)) begin
            res.action    = ACT_STALL;
            st_next.phase = PH_IDLE;
          end else begin
            st_next.rx_left = rx_rem;
          end
        end
        PH_STATUS_OUT: begin
          st_next.phase = PH_IDLE;
          res.complete  = 1'b1;
        end
        default: begin
          res.action    = ACT_STALL;
          st_next.phase = PH_IDLE;
        end
      endcase
    end else if (do_in) begin
      unique case (st.phase)
        PH_TXZLP: begin
          res.action    = ACT_ZLP;
          st_next.phase = PH_TXCOMP;
        end
        PH_TXCOMP:    st_next.phase = PH_STATUS_OUT;
        PH_STATUS_IN: begin
          st_next.phase = PH_IDLE;
          res.complete  = 1'b1;
        end
        default: ;
      endcase
    end

    if (want_process) begin
      res.request_taken = 1'b1;
      unique case (item.handler_resp)
        RESP_ACK: begin
          if (lth) begin
            st_next.phase = PH_TXDATA;
          end else begin
            res.action    = ACT_ZLP;
            st_next.phase = PH_STATUS_IN;
          end
        end
        RESP_NAK, RESP_FAIL: st_next.phase = PH_STATUS_IN;
        default: begin
          res.action    = ACT_STALL;
          st_next.phase = PH_IDLE;
        end
      endcase
    end

    if (want_send) begin
      if (snd_n != '0) begin
        res.action    = ACT_DATA;
        res.in_len    = snd_n[PKT_W-1:0];
        res.in_offset = snd_base;
      end else begin
        res.action = ACT_ZLP;
      end
      st_next.tx_sent = snd_base + snd_n;
      st_next.tx_left = snd_left_next;
      if (snd_left_next == '0) begin
        st_next.phase = (snd_n != mp_ext) ? PH_TXCOMP : PH_TXZLP;
      end
    end

    res.phase = st_next.phase;
  end

endmodule

@@ rtl/core/usb_ep0_control_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// usb_ep0_control_sequencer_unit - USB endpoint-zero control sequencer
// Follows control transfers through setup, data and status stages and
// answers each endpoint event with one action.
// ----------------------------------------------------------------------------
//  channel  | dir | payload      | meaning
//  ---------+-----+--------------+--------------------------------------------
//  item     | in  | item_t       | endpoint event and handler answer
//  result   | out | result_t     | endpoint action, packet slice, phase
//  cfg      | in  | cfg_write_t  | register write (max_packet, rx_capacity)
//
//  one event per clock sustained while the result is taken; the result is
//  registered through the input register, then the result register
//  the sequencer state is updated in the cycle an event moves from the input
//  register into the result register, so consecutive events chain directly
//  a stalled result holds the result register; the input register still
//  takes one more event, then item.ready drops until the result moves on
//  synchronous active-high reset: pipeline empty, phase idle, counters zero,
//  max_packet 64, rx_capacity 256; cfg is always ready
// ----------------------------------------------------------------------------
module usb_ep0_control_sequencer_unit
  import uep0_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  uep0_stream_if.sink   item,
  uep0_stream_if.source result,
  uep0_stream_if.sink   cfg
);

  // configuration registers
  cfg_regs_t  regs;

  // input register
  logic       in_valid;
  item_t      in_item;

  // result register
  logic       out_valid;
  result_t    out_res;

  // sequencer state
  seq_state_t st;
  seq_state_t st_next;
  result_t    res_next;

  logic       advance;
  logic       in_take;
  cfg_write_t cfg_wr;

  // an event moves on when the result register is free or being drained
  assign advance = in_valid && (!out_valid || result.ready);
  assign in_take = item.valid && item.ready;
  assign cfg_wr  = cfg.data;

  assign item.ready   = !in_valid || advance;
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.data  = out_res;

  // configuration writes, accepted in any cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_packet  <= MAX_PACKET_RST;
      regs.rx_capacity <= RX_CAPACITY_RST;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg_wr.index))
        CFG_MAX_PACKET:  regs.max_packet  <= cfg_wr.value[PKT_W-1:0];
        CFG_RX_CAPACITY: regs.rx_capacity <= cfg_wr.value[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item <= item.data;
    end
  end

  // event logic between the two registers
  uep0_step u_step (
    .item    (in_item),
    .st      (st),
    .regs    (regs),
    .st_next (st_next),
    .res     (res_next)
  );

  // sequencer state, updated as the event is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase           <= PH_IDLE;
      st.rx_left         <= '0;
      st.tx_left         <= '0;
      st.tx_sent         <= '0;
      st.latched_to_host <= 1'b0;
      st.latched_length  <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

`ifndef ASSERT_OFF
  // a data packet always carries bytes, anything else carries no slice
  a_data_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.action == ACT_DATA |-> out_res.in_len != '0)
    else $error("data packet with zero length");

  a_slice_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.action != ACT_DATA |->
      out_res.in_len == '0 && out_res.in_offset == '0)
    else $error("packet slice on a non-data action");

  // stall and completion both leave the sequencer idle
  a_stall_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.action == ACT_STALL || out_res.complete) |->
      out_res.phase == PH_IDLE)
    else $error("stall or completion without idle phase");

  // the committed state follows the reported phase
  a_phase_track: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_res.phase == st.phase)
    else $error("reported phase differs from state");
`endif

endmodule
